### hw/rtl/nv21rs_pkg.sv
// Shared widths, color matrix constants and helpers for the NV21 resize block.
package nv21rs_pkg;

    localparam int FRAC_BITS_DEF = 11;
    localparam int FRAC_W        = 12;
    localparam int QUAD_W        = 32;
    localparam int PIX_W         = 8;
    localparam int ACC_W         = 20;

    localparam logic signed [ACC_W-1:0] Y_OFFSET   = 20'sd16;
    localparam logic signed [ACC_W-1:0] C_CENTER   = 20'sd128;
    localparam logic signed [ACC_W-1:0] CSC_ROUND  = 20'sd128;
    localparam logic signed [ACC_W-1:0] K_Y        = 20'sd298;
    localparam logic signed [ACC_W-1:0] K_RV       = 20'sd409;
    localparam logic signed [ACC_W-1:0] K_GU       = 20'sd100;
    localparam logic signed [ACC_W-1:0] K_GV       = 20'sd208;
    localparam logic signed [ACC_W-1:0] K_BU       = 20'sd516;

    typedef struct packed {
        logic hor;
        logic ver;
    } t_stage_en;

    function automatic logic [PIX_W-1:0] to_chan(input logic signed [ACC_W-1:0] a);
        logic [PIX_W-1:0] res;
        if (a[ACC_W-1]) begin
            res = '0;
        end else if (|a[ACC_W-2:PIX_W+8]) begin
            res = '1;
        end else begin
            res = a[PIX_W+7:8];
        end
        return res;
    endfunction

endpackage

### hw/rtl/nv21rs_lerp.sv
// Two-stage separable bilinear interpolator for one 2x2 plane neighborhood.
module nv21rs_lerp #(
    parameter int FRAC_BITS = nv21rs_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  nv21rs_pkg::t_stage_en           i_en,
    input  logic [nv21rs_pkg::QUAD_W-1:0]   i_quad,
    input  logic [FRAC_BITS:0]              i_fx,
    input  logic [FRAC_BITS:0]              i_fxc,
    input  logic [FRAC_BITS:0]              i_fy,
    input  logic [FRAC_BITS:0]              i_fyc,
    output logic [nv21rs_pkg::PIX_W-1:0]    o_pix
);
    localparam int WW = FRAC_BITS + 1;
    localparam int HW = nv21rs_pkg::PIX_W + FRAC_BITS;
    localparam int SW = nv21rs_pkg::PIX_W + 1 + 2 * FRAC_BITS;
    localparam logic [SW-1:0] BIAS = SW'(1) << (2 * FRAC_BITS - 1);

    logic [HW-1:0] n_top;
    logic [HW-1:0] n_bot;
    logic [HW-1:0] r_top;
    logic [HW-1:0] r_bot;
    logic [WW-1:0] r_fy;
    logic [WW-1:0] r_fyc;
    logic [SW-1:0] n_sum;
    logic [SW-2*FRAC_BITS-1:0] n_val;
    logic [nv21rs_pkg::PIX_W-1:0] r_pix;

    always_comb begin
        n_top = HW'(HW'(i_quad[7:0]) * HW'(i_fxc) + HW'(i_quad[15:8]) * HW'(i_fx));
        n_bot = HW'(HW'(i_quad[23:16]) * HW'(i_fxc) + HW'(i_quad[31:24]) * HW'(i_fx));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.hor) begin
            r_top <= n_top;
            r_bot <= n_bot;
            r_fy  <= i_fy;
            r_fyc <= i_fyc;
        end
    end

    always_comb begin
        n_sum = SW'(r_top) * SW'(r_fyc) + SW'(r_bot) * SW'(r_fy) + BIAS;
        n_val = n_sum[SW-1:2*FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ver) begin
            if (n_val > (SW-2*FRAC_BITS)'(255)) begin
                r_pix <= '1;
            end else begin
                r_pix <= n_val[nv21rs_pkg::PIX_W-1:0];
            end
        end
    end

    assign o_pix = r_pix;

endmodule

### hw/rtl/nv21rs_csc.sv
// BT.601 limited-range YUV to RGB conversion stage with output clamping.
module nv21rs_csc (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [nv21rs_pkg::PIX_W-1:0]  i_y,
    input  logic [nv21rs_pkg::PIX_W-1:0]  i_v,
    input  logic [nv21rs_pkg::PIX_W-1:0]  i_u,
    output logic [nv21rs_pkg::PIX_W-1:0]  o_red,
    output logic [nv21rs_pkg::PIX_W-1:0]  o_green,
    output logic [nv21rs_pkg::PIX_W-1:0]  o_blue
);
    localparam int AW = nv21rs_pkg::ACC_W;

    logic signed [AW-1:0] n_ys;
    logic signed [AW-1:0] n_vc;
    logic signed [AW-1:0] n_uc;
    logic signed [AW-1:0] n_r;
    logic signed [AW-1:0] n_g;
    logic signed [AW-1:0] n_b;
    logic [nv21rs_pkg::PIX_W-1:0] r_red;
    logic [nv21rs_pkg::PIX_W-1:0] r_green;
    logic [nv21rs_pkg::PIX_W-1:0] r_blue;

    always_comb begin
        n_ys = (signed'(AW'(i_y)) - nv21rs_pkg::Y_OFFSET) * nv21rs_pkg::K_Y
               + nv21rs_pkg::CSC_ROUND;
        n_vc = signed'(AW'(i_v)) - nv21rs_pkg::C_CENTER;
        n_uc = signed'(AW'(i_u)) - nv21rs_pkg::C_CENTER;
        n_r  = n_ys + nv21rs_pkg::K_RV * n_vc;
        n_g  = n_ys - nv21rs_pkg::K_GU * n_uc - nv21rs_pkg::K_GV * n_vc;
        n_b  = n_ys + nv21rs_pkg::K_BU * n_uc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= nv21rs_pkg::to_chan(n_r);
            r_green <= nv21rs_pkg::to_chan(n_g);
            r_blue  <= nv21rs_pkg::to_chan(n_b);
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

### hw/rtl/nv21_bilinear_resize_to_rgb_top.sv
// Top level of the NV21 bilinear resample and RGB conversion pipeline.
//
// Input channel: one beat per output pixel carries the 2x2 luma, V and U
// neighborhoods and the luma and chroma weights, under i_valid and o_stall.
// Output channel: one beat per input beat carries red, green and blue,
// under o_valid and i_stall.
// The pipeline has four register stages: weight saturation, horizontal
// interpolation, vertical interpolation with rounding, and the color matrix
// with clamping. Throughput is one pixel per cycle unless i_stall holds it.
// Each stage advances when its successor is empty or advancing, so bubbles
// are squeezed out while the receiver stalls. The block keeps accepting
// beats until every stage holds a pixel, then raises o_stall.
// Reset clears all stage valid bits; no beat is in flight afterward.
module nv21_bilinear_resize_to_rgb_top #(
    parameter int FRAC_BITS = nv21rs_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [nv21rs_pkg::QUAD_W-1:0] i_luma_quad,
    input  logic [nv21rs_pkg::FRAC_W-1:0] i_luma_frac_x,
    input  logic [nv21rs_pkg::FRAC_W-1:0] i_luma_frac_y,
    input  logic [nv21rs_pkg::QUAD_W-1:0] i_v_quad,
    input  logic [nv21rs_pkg::QUAD_W-1:0] i_u_quad,
    input  logic [nv21rs_pkg::FRAC_W-1:0] i_chroma_frac_x,
    input  logic [nv21rs_pkg::FRAC_W-1:0] i_chroma_frac_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [nv21rs_pkg::PIX_W-1:0]  o_red,
    output logic [nv21rs_pkg::PIX_W-1:0]  o_green,
    output logic [nv21rs_pkg::PIX_W-1:0]  o_blue
);
    localparam int WW = FRAC_BITS + 1;
    localparam int CW = (WW > nv21rs_pkg::FRAC_W) ? WW : nv21rs_pkg::FRAC_W;
    localparam logic [WW-1:0] FULL = WW'(1) << FRAC_BITS;

    function automatic logic [WW-1:0] sat_w(input logic [nv21rs_pkg::FRAC_W-1:0] f);
        logic [CW-1:0] fe;
        logic [WW-1:0] res;
        fe = CW'(f);
        if (fe > CW'(FULL)) begin
            res = FULL;
        end else begin
            res = fe[WW-1:0];
        end
        return res;
    endfunction

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    nv21rs_pkg::t_stage_en lerp_en;

    logic [nv21rs_pkg::QUAD_W-1:0] r_luma_quad;
    logic [nv21rs_pkg::QUAD_W-1:0] r_v_quad;
    logic [nv21rs_pkg::QUAD_W-1:0] r_u_quad;
    logic [WW-1:0] r_lfx;
    logic [WW-1:0] r_lfxc;
    logic [WW-1:0] r_lfy;
    logic [WW-1:0] r_lfyc;
    logic [WW-1:0] r_cfx;
    logic [WW-1:0] r_cfxc;
    logic [WW-1:0] r_cfy;
    logic [WW-1:0] r_cfyc;
    logic [WW-1:0] n_lfx;
    logic [WW-1:0] n_lfy;
    logic [WW-1:0] n_cfx;
    logic [WW-1:0] n_cfy;

    logic [nv21rs_pkg::PIX_W-1:0] y_pix;
    logic [nv21rs_pkg::PIX_W-1:0] v_pix;
    logic [nv21rs_pkg::PIX_W-1:0] u_pix;

    always_comb begin
        en4 = !r_v4 || !i_stall;
        en3 = !r_v3 || en4;
        en2 = !r_v2 || en3;
        en1 = !r_v1 || en2;
        lerp_en.hor = en2;
        lerp_en.ver = en3;
    end

    assign o_stall = !en1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_comb begin
        n_lfx = sat_w(i_luma_frac_x);
        n_lfy = sat_w(i_luma_frac_y);
        n_cfx = sat_w(i_chroma_frac_x);
        n_cfy = sat_w(i_chroma_frac_y);
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_luma_quad <= i_luma_quad;
            r_v_quad    <= i_v_quad;
            r_u_quad    <= i_u_quad;
            r_lfx       <= n_lfx;
            r_lfxc      <= FULL - n_lfx;
            r_lfy       <= n_lfy;
            r_lfyc      <= FULL - n_lfy;
            r_cfx       <= n_cfx;
            r_cfxc      <= FULL - n_cfx;
            r_cfy       <= n_cfy;
            r_cfyc      <= FULL - n_cfy;
        end
    end

    nv21rs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_y (
        .i_clk  (i_clk),
        .i_en   (lerp_en),
        .i_quad (r_luma_quad),
        .i_fx   (r_lfx),
        .i_fxc  (r_lfxc),
        .i_fy   (r_lfy),
        .i_fyc  (r_lfyc),
        .o_pix  (y_pix)
    );

    nv21rs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_v (
        .i_clk  (i_clk),
        .i_en   (lerp_en),
        .i_quad (r_v_quad),
        .i_fx   (r_cfx),
        .i_fxc  (r_cfxc),
        .i_fy   (r_cfy),
        .i_fyc  (r_cfyc),
        .o_pix  (v_pix)
    );

    nv21rs_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_u (
        .i_clk  (i_clk),
        .i_en   (lerp_en),
        .i_quad (r_u_quad),
        .i_fx   (r_cfx),
        .i_fxc  (r_cfxc),
        .i_fy   (r_cfy),
        .i_fyc  (r_cfyc),
        .o_pix  (u_pix)
    );

    nv21rs_csc u_csc (
        .i_clk   (i_clk),
        .i_en    (en4),
        .i_y     (y_pix),
        .i_v     (v_pix),
        .i_u     (u_pix),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

### hw/rtl/nv21rs_checker.sv
// Port-level checker for the NV21 resize pipeline and its bind statement.
module nv21rs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [nv21rs_pkg::PIX_W-1:0]  o_red,
    input logic [nv21rs_pkg::PIX_W-1:0]  o_green,
    input logic [nv21rs_pkg::PIX_W-1:0]  o_blue
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("Output beat dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_red) && $stable(o_green) && $stable(o_blue)))
        else $error("Output pixel changed while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("Input stalled although the output stage is empty.");

endmodule

bind nv21_bilinear_resize_to_rgb_top nv21rs_checker u_nv21rs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_red   (o_red),
    .o_green (o_green),
    .o_blue  (o_blue)
);

### dv/nv21_bilinear_resize_to_rgb_top_tb.sv
// Self-checking testbench for the NV21 bilinear resample to RGB pipeline.
module nv21_bilinear_resize_to_rgb_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nv21rs_pkg::*;

    localparam int RANDOM_BEATS = 550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        logic [QUAD_W-1:0] luma_quad;
        logic [FRAC_W-1:0] luma_fx;
        logic [FRAC_W-1:0] luma_fy;
        logic [QUAD_W-1:0] v_quad;
        logic [QUAD_W-1:0] u_quad;
        logic [FRAC_W-1:0] chroma_fx;
        logic [FRAC_W-1:0] chroma_fy;
    } sample_t;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    class rgb_tracker;
        localparam longint unsigned FULL = longint'(1) << FRAC_BITS_DEF;
        localparam longint unsigned BIAS = longint'(1) << (2 * FRAC_BITS_DEF - 1);

        rgb_t expected_rgb[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function automatic int interp(logic [QUAD_W-1:0] quad, logic [FRAC_W-1:0] fx_raw,
                                      logic [FRAC_W-1:0] fy_raw);
            longint unsigned fx, fy, top, bot, v;
            fx = (fx_raw > FULL) ? FULL : longint'(fx_raw);
            fy = (fy_raw > FULL) ? FULL : longint'(fy_raw);
            top = longint'(quad[7:0]) * (FULL - fx) + longint'(quad[15:8]) * fx;
            bot = longint'(quad[23:16]) * (FULL - fx) + longint'(quad[31:24]) * fx;
            v = (top * (FULL - fy) + bot * fy + BIAS) >> (2 * FRAC_BITS_DEF);
            if (v > 255) begin
                v = 255;
            end
            return int'(v);
        endfunction

        function automatic logic [PIX_W-1:0] clamp_chan(int acc);
            int v;
            if (acc < 0) begin
                return '0;
            end
            v = acc / 256;
            return (v > 255) ? 8'hFF : v[PIX_W-1:0];
        endfunction

        function automatic rgb_t rgb_of_sample(sample_t s);
            rgb_t p;
            int   y, cv, cu, ys;
            y  = interp(s.luma_quad, s.luma_fx, s.luma_fy);
            cv = interp(s.v_quad, s.chroma_fx, s.chroma_fy) - 128;
            cu = interp(s.u_quad, s.chroma_fx, s.chroma_fy) - 128;
            ys = (y - 16) * 298 + 128;
            p.red   = clamp_chan(ys + 409 * cv);
            p.green = clamp_chan(ys - 100 * cu - 208 * cv);
            p.blue  = clamp_chan(ys + 516 * cu);
            return p;
        endfunction

        function void note_sample(sample_t s);
            expected_rgb.push_back(rgb_of_sample(s));
        endfunction

        function void check_rgb(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                logic [PIX_W-1:0] b);
            rgb_t want;
            if (expected_rgb.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected output beat: r=%0d g=%0d b=%0d", r, g, b);
                end
                return;
            end
            want = expected_rgb.pop_front();
            if (want.red !== r || want.green !== g || want.blue !== b) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                             want.red, want.green, want.blue, r, g, b);
                end
            end
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [QUAD_W-1:0] i_luma_quad = '0;
    logic [FRAC_W-1:0] i_luma_frac_x = '0;
    logic [FRAC_W-1:0] i_luma_frac_y = '0;
    logic [QUAD_W-1:0] i_v_quad = '0;
    logic [QUAD_W-1:0] i_u_quad = '0;
    logic [FRAC_W-1:0] i_chroma_frac_x = '0;
    logic [FRAC_W-1:0] i_chroma_frac_y = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [PIX_W-1:0]  o_red;
    logic [PIX_W-1:0]  o_green;
    logic [PIX_W-1:0]  o_blue;

    logic              calm = 1'b0;
    int                cycles = 0;
    rgb_tracker        tracker = new();

    nv21_bilinear_resize_to_rgb_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_luma_quad     (i_luma_quad),
        .i_luma_frac_x   (i_luma_frac_x),
        .i_luma_frac_y   (i_luma_frac_y),
        .i_v_quad        (i_v_quad),
        .i_u_quad        (i_u_quad),
        .i_chroma_frac_x (i_chroma_frac_x),
        .i_chroma_frac_y (i_chroma_frac_y),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 33);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_rgb(o_red, o_green, o_blue);
        end
    end

    function automatic sample_t mk(logic [QUAD_W-1:0] lq, logic [FRAC_W-1:0] lfx,
                                   logic [FRAC_W-1:0] lfy, logic [QUAD_W-1:0] vq,
                                   logic [QUAD_W-1:0] uq, logic [FRAC_W-1:0] cfx,
                                   logic [FRAC_W-1:0] cfy);
        sample_t s;
        s.luma_quad = lq;
        s.luma_fx   = lfx;
        s.luma_fy   = lfy;
        s.v_quad    = vq;
        s.u_quad    = uq;
        s.chroma_fx = cfx;
        s.chroma_fy = cfy;
        return s;
    endfunction

    function automatic logic [FRAC_W-1:0] rand_weight();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            return FRAC_W'($urandom_range(0, 2048));
        end else if (pick < 85) begin
            return ($urandom_range(0, 1) != 0) ? FRAC_W'(2048) : FRAC_W'(0);
        end
        return FRAC_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [QUAD_W-1:0] rand_quad();
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(0, 99) < 20) begin
            return {b, b, b, b};
        end
        return $urandom;
    endfunction

    task automatic send_sample(sample_t s);
        while (!calm && $urandom_range(0, 99) < 33) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_luma_quad     <= s.luma_quad;
        i_luma_frac_x   <= s.luma_fx;
        i_luma_frac_y   <= s.luma_fy;
        i_v_quad        <= s.v_quad;
        i_u_quad        <= s.u_quad;
        i_chroma_frac_x <= s.chroma_fx;
        i_chroma_frac_y <= s.chroma_fy;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        tracker.note_sample(s);
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        sample_t s;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample(mk(32'h0, 12'd0, 12'd0, 32'h0, 32'h0, 12'd0, 12'd0));
        send_sample(mk('1, 12'd2048, 12'd2048, '1, '1, 12'd2048, 12'd2048));
        send_sample(mk('1, 12'd1024, 12'd1024, '1, 32'h0, 12'd1024, 12'd1024));
        send_sample(mk(32'h00FF00FF, 12'd1024, 12'd1024, 32'hFF00FF00, 32'h00FF00FF,
                       12'd1024, 12'd1024));
        send_sample(mk(32'h04C38241, 12'd4095, 12'd4095, 32'h10203040, 32'h50607080,
                       12'd4095, 12'd4095));
        send_sample(mk(32'h04C38241, 12'd2049, 12'd3000, 32'h10203040, 32'h50607080,
                       12'd2049, 12'd2500));
        send_sample(mk(32'h04C38241, 12'd0, 12'd0, 32'hF0A05010, 32'h0F5AA5F0,
                       12'd0, 12'd0));
        send_sample(mk(32'h04C38241, 12'd2048, 12'd0, 32'hF0A05010, 32'h0F5AA5F0,
                       12'd2048, 12'd0));
        send_sample(mk(32'h04C38241, 12'd0, 12'd2048, 32'hF0A05010, 32'h0F5AA5F0,
                       12'd0, 12'd2048));
        send_sample(mk(32'h04C38241, 12'd2048, 12'd2048, 32'hF0A05010, 32'h0F5AA5F0,
                       12'd2048, 12'd2048));
        send_sample(mk(32'h10101010, 12'd5, 12'd7, 32'h80808080, 32'h80808080,
                       12'd9, 12'd11));
        send_sample(mk('1, 12'd0, 12'd0, '1, 32'h0, 12'd0, 12'd0));
        send_sample(mk('1, 12'd0, 12'd0, 32'h0, '1, 12'd0, 12'd0));
        send_sample(mk(32'h0, 12'd0, 12'd0, '1, '1, 12'd0, 12'd0));
        send_sample(mk(32'h0, 12'd0, 12'd0, 32'h0, 32'h0, 12'd0, 12'd0));
        send_sample(mk(32'h7F80FF01, 12'h7FF, 12'h001, 32'hFE01807F, 32'h01FE7F80,
                       12'h001, 12'h7FF));
        send_sample(mk(32'hEB10EB10, 12'h800, 12'hFFF, 32'hF010F010, 32'h10F010F0,
                       12'hFFF, 12'h800));
        send_sample(mk(32'hA5A5A5A5, 12'h555, 12'hAAA, 32'h5A5A5A5A, 32'hC3C33C3C,
                       12'hAAA, 12'h555));

        i_valid <= 1'b0;
        wait_drained();

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == 200) begin
                calm <= 1'b1;
            end else if (n == 300) begin
                calm <= 1'b0;
            end
            s = mk(rand_quad(), rand_weight(), rand_weight(), rand_quad(), rand_quad(),
                   rand_weight(), rand_weight());
            send_sample(s);
        end
        i_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### nv21_bilinear_resize_to_rgb_top.f
hw/rtl/nv21rs_pkg.sv
hw/rtl/nv21rs_lerp.sv
hw/rtl/nv21rs_csc.sv
hw/rtl/nv21_bilinear_resize_to_rgb_top.sv
hw/rtl/nv21rs_checker.sv
dv/nv21_bilinear_resize_to_rgb_top_tb.sv
